// ===== hdl/ptz_pkg.sv =====
package ptz_pkg;

  // Field widths.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned DEN_W   = 16;
  localparam int unsigned QUO_W   = 28;

  // Stream packing.
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  // Geometry constants.
  localparam logic signed [DIFF_W-1:0] MIN_DEPTH = 17'sd64;
  localparam logic signed [QUO_W-1:0]  CLAMP_LIM = 28'sd32752;
  localparam logic signed [DIFF_W:0]   WINDOW    = 18'sd4096;

  // One divider lane: the dividend bits still to consume sit at the top of
  // nq, and quotient bits shift in at the bottom.
  typedef struct packed {
    logic [DIV_W-1:0] nq;
    logic [DEN_W-1:0] rem;
  } div_lane_t;

  // Values that ride alongside the divider.
  typedef struct packed {
    logic                      shallow;
    logic                      neg_x;
    logic                      neg_y;
    logic [DEN_W-1:0]          den;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] pz;
  } side_t;

endpackage

// ===== hdl/project_segment_to_z_plane_core.sv =====
// Channel   Direction  Contents
// in_*      input      one segment: start x/y/z, end x/y/z, plane depth
// out_*     output     projected point with point_valid and reject flags
//
// A new segment is taken every cycle unless the output stalls; it passes the
// 32-stage divider (one quotient bit a stage) on its way to the output register.
// Reset clears the valid bits of every stage; data registers are not reset.
// When the output holds an untaken result, the whole pipeline freezes and
// in_tready drops in the same cycle; nothing is lost or repeated.
module project_segment_to_z_plane_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, plane_z
  input  logic [ptz_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_x, out_y, out_z
  output logic [ptz_pkg::OUT_DATA_W-1:0] out_tdata,
  // point_valid, reject
  output logic [ptz_pkg::OUT_USER_W-1:0] out_tuser
);
  import ptz_pkg::*;

  logic en;
  logic dv_valid;

  // Unpack the input transfer.
  logic signed [COORD_W-1:0] sx, sy, sz, ex, ey, ez, pz;
  assign sx = in_tdata[15:0];
  assign sy = in_tdata[31:16];
  assign sz = in_tdata[47:32];
  assign ex = in_tdata[63:48];
  assign ey = in_tdata[79:64];
  assign ez = in_tdata[95:80];
  assign pz = in_tdata[111:96];

  // Stage 1: differences.
  logic                     v1_r;
  logic signed [DIFF_W-1:0] depth1_r, off1_r, dx1_r, dy1_r;
  logic signed [COORD_W-1:0] sx1_r, sy1_r, ex1_r, ey1_r, pz1_r;

  // Stage 2: wrapped products.
  logic                     v2_r;
  logic                     shallow2_r;
  logic [DEN_W-1:0]         den2_r;
  logic [DIV_W-1:0]         px2_r, py2_r;
  logic signed [COORD_W-1:0] sx2_r, sy2_r, ex2_r, ey2_r, pz2_r;

  // Stage after divider: signed sums.
  logic                     v3_r;
  logic                     shallow3_r;
  logic signed [QUO_W-1:0]  sumx3_r, sumy3_r;
  logic signed [COORD_W-1:0] sx3_r, sy3_r, pz3_r;

  // Output register.
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;
  logic [OUT_USER_W-1:0]     out_user_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= dv_valid;
      out_valid_r <= v3_r;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (en) begin
      depth1_r <= DIFF_W'(ez) - DIFF_W'(sz);
      off1_r   <= DIFF_W'(pz) - DIFF_W'(ez);
      dx1_r    <= DIFF_W'(ex) - DIFF_W'(sx);
      dy1_r    <= DIFF_W'(ey) - DIFF_W'(sy);
      sx1_r <= sx;
      sy1_r <= sy;
      ex1_r <= ex;
      ey1_r <= ey;
      pz1_r <= pz;
    end
  end

  // Stage 2: multiply, keep the low 32 bits.
  logic signed [2*DIFF_W-1:0] prod_x, prod_y;
  assign prod_x = dx1_r * off1_r;
  assign prod_y = dy1_r * off1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      shallow2_r <= depth1_r < MIN_DEPTH;
      den2_r     <= depth1_r[DEN_W-1:0];
      px2_r      <= prod_x[DIV_W-1:0];
      py2_r      <= prod_y[DIV_W-1:0];
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
      ex2_r <= ex1_r;
      ey2_r <= ey1_r;
      pz2_r <= pz1_r;
    end
  end

  // Divide magnitudes; the depth is positive, so the quotient takes the
  // sign of the product.
  side_t            dv_in_side, dv_side;
  logic [DIV_W-1:0] mag_x, mag_y, quo_x, quo_y;

  assign mag_x = px2_r[DIV_W-1] ? DIV_W'(-px2_r) : px2_r;
  assign mag_y = py2_r[DIV_W-1] ? DIV_W'(-py2_r) : py2_r;

  always_comb begin
    dv_in_side.shallow = shallow2_r;
    dv_in_side.neg_x   = px2_r[DIV_W-1];
    dv_in_side.neg_y   = py2_r[DIV_W-1];
    dv_in_side.den     = den2_r;
    dv_in_side.sx      = sx2_r;
    dv_in_side.sy      = sy2_r;
    dv_in_side.ex      = ex2_r;
    dv_in_side.ey      = ey2_r;
    dv_in_side.pz      = pz2_r;
  end

  ptz_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_side   (dv_in_side),
    .in_num_x  (mag_x),
    .in_num_y  (mag_y),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .out_quo_x (quo_x),
    .out_quo_y (quo_y)
  );

  // Restore the sign and add the end coordinate.
  logic signed [QUO_W-1:0] qx, qy;
  assign qx = dv_side.neg_x ? -$signed({1'b0, quo_x[QUO_W-2:0]})
                            :  $signed({1'b0, quo_x[QUO_W-2:0]});
  assign qy = dv_side.neg_y ? -$signed({1'b0, quo_y[QUO_W-2:0]})
                            :  $signed({1'b0, quo_y[QUO_W-2:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      shallow3_r <= dv_side.shallow;
      sumx3_r    <= qx + QUO_W'(dv_side.ex);
      sumy3_r    <= qy + QUO_W'(dv_side.ey);
      sx3_r      <= dv_side.sx;
      sy3_r      <= dv_side.sy;
      pz3_r      <= dv_side.pz;
    end
  end

  // Clamp and window test.
  logic signed [COORD_W-1:0] cx, cy;
  logic                      rej_x, rej_y;

  always_comb begin
    priority if (sumx3_r < -CLAMP_LIM) begin
      cx = COORD_W'(-CLAMP_LIM);
    end else if (sumx3_r > CLAMP_LIM) begin
      cx = COORD_W'(CLAMP_LIM);
    end else begin
      cx = sumx3_r[COORD_W-1:0];
    end
    priority if (sumy3_r < -CLAMP_LIM) begin
      cy = COORD_W'(-CLAMP_LIM);
    end else if (sumy3_r > CLAMP_LIM) begin
      cy = COORD_W'(CLAMP_LIM);
    end else begin
      cy = sumy3_r[COORD_W-1:0];
    end
    rej_x = ((DIFF_W+1)'(cx) < (DIFF_W+1)'(sx3_r) - WINDOW) ||
            ((DIFF_W+1)'(cx) > (DIFF_W+1)'(sx3_r) + WINDOW);
    rej_y = ((DIFF_W+1)'(cy) < (DIFF_W+1)'(sy3_r) - WINDOW) ||
            ((DIFF_W+1)'(cy) > (DIFF_W+1)'(sy3_r) + WINDOW);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (shallow3_r) begin
        out_data_r <= '0;
        out_user_r <= 2'b10;
      end else begin
        out_data_r <= {pz3_r, cy, cx};
        out_user_r <= {rej_x || rej_y, 1'b1};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hdl/ptz_div.sv =====
module ptz_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  ptz_pkg::side_t           in_side,
  input  logic [ptz_pkg::DIV_W-1:0] in_num_x,
  input  logic [ptz_pkg::DIV_W-1:0] in_num_y,
  output logic                     out_valid,
  output ptz_pkg::side_t           out_side,
  output logic [ptz_pkg::DIV_W-1:0] out_quo_x,
  output logic [ptz_pkg::DIV_W-1:0] out_quo_y
);
  import ptz_pkg::*;

  logic      v_r    [DIV_W];
  side_t     side_r [DIV_W];
  div_lane_t lx_r   [DIV_W];
  div_lane_t ly_r   [DIV_W];
  div_lane_t lx_nxt [DIV_W];
  div_lane_t ly_nxt [DIV_W];

  // One restoring step: bring down one dividend bit, subtract if it fits.
  function automatic div_lane_t div_step(div_lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    logic           fits;
    div_lane_t      r;
    trial = {l.rem, l.nq[DIV_W-1]};
    fits  = (trial >= {1'b0, den});
    r.rem = fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    r.nq  = {l.nq[DIV_W-2:0], fits};
    return r;
  endfunction

  // Each stage resolves one quotient bit for both axes.
  always_comb begin
    lx_nxt[0] = div_step('{nq: in_num_x, rem: '0}, in_side.den);
    ly_nxt[0] = div_step('{nq: in_num_y, rem: '0}, in_side.den);
    for (int k = 1; k < DIV_W; k++) begin
      lx_nxt[k] = div_step(lx_r[k-1], side_r[k-1].den);
      ly_nxt[k] = div_step(ly_r[k-1], side_r[k-1].den);
    end
  end

  // Valid bits travel with the data; the whole chain holds on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_W; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < DIV_W; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_W; k++) begin
        side_r[k] <= side_r[k-1];
      end
      for (int k = 0; k < DIV_W; k++) begin
        lx_r[k] <= lx_nxt[k];
        ly_r[k] <= ly_nxt[k];
      end
    end
  end

  assign out_valid = v_r[DIV_W-1];
  assign out_side  = side_r[DIV_W-1];
  assign out_quo_x = lx_r[DIV_W-1].nq;
  assign out_quo_y = ly_r[DIV_W-1].nq;

endmodule

// ===== dv/tb_top.sv =====
// Scoreboard for projected points: holds the expected result of each segment
// that has been transferred in but not yet checked, oldest first.
class proj_scoreboard;
  typedef struct packed {
    logic              point_valid;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic              reject;
  } point_t;

  point_t pending_points[$];
  int     errors;
  int     n_checked;
  int     n_rejected;

  // Extend one coordinate to the plane, then clamp it.
  function automatic logic signed [31:0] extend(logic signed [15:0] s, logic signed [15:0] e,
                                                logic signed [31:0] offset,
                                                logic signed [31:0] depth);
    logic signed [31:0] diff;
    logic signed [31:0] prod;
    longint             v;
    diff = 32'(e) - 32'(s);
    prod = diff * offset;  // keeps the low 32 bits
    v = longint'(prod / depth) + longint'(e);
    if (v < -32752) v = -32752;
    if (v > 32752) v = 32752;
    return 32'(v);
  endfunction

  // Note an accepted segment and queue its expected point.
  function void note_segment(logic [111:0] d);
    logic signed [15:0] sx, sy, sz, ex, ey, ez, pz;
    logic signed [31:0] depth, offset, ox, oy;
    point_t p;
    {pz, ez, ey, ex, sz, sy, sx} = d;
    depth = 32'(ez) - 32'(sz);
    p = '0;
    if (depth < 64) begin
      p.reject = 1'b1;
    end else begin
      offset = 32'(pz) - 32'(ez);
      ox = extend(sx, ex, offset, depth);
      oy = extend(sy, ey, offset, depth);
      p.point_valid = 1'b1;
      p.x = ox[15:0];
      p.y = oy[15:0];
      p.z = pz;
      p.reject = (ox < 32'(sx) - 4096) || (ox > 32'(sx) + 4096) ||
                 (oy < 32'(sy) - 4096) || (oy > 32'(sy) + 4096);
    end
    pending_points.push_back(p);
  endfunction

  // Compare a transferred result with the oldest expectation.
  function void check_point(logic [47:0] d, logic [1:0] u);
    point_t e;
    point_t a;
    a = {u[0], d[15:0], d[31:16], d[47:32], u[1]};
    if (pending_points.size() == 0) begin
      $display("%0t: unexpected result x=%0d y=%0d z=%0d flags=%b", $realtime,
               $signed(a.x), $signed(a.y), $signed(a.z), u);
      errors++;
      return;
    end
    e = pending_points.pop_front();
    n_checked++;
    if (e.reject) n_rejected++;
    if (a.point_valid !== e.point_valid) begin
      $display("%0t: point_valid expected %0b actual %0b", $realtime, e.point_valid,
               a.point_valid);
      errors++;
    end
    if (a.x !== e.x) begin
      $display("%0t: out_x expected %0d actual %0d", $realtime, e.x, a.x);
      errors++;
    end
    if (a.y !== e.y) begin
      $display("%0t: out_y expected %0d actual %0d", $realtime, e.y, a.y);
      errors++;
    end
    if (a.z !== e.z) begin
      $display("%0t: out_z expected %0d actual %0d", $realtime, e.z, a.z);
      errors++;
    end
    if (a.reject !== e.reject) begin
      $display("%0t: reject expected %0b actual %0b", $realtime, e.reject, a.reject);
      errors++;
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ptz_pkg::*;

  localparam int N_RANDOM   = 1500;
  localparam int STALL_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  proj_scoreboard sb = new();
  bit calm = 1'b0;   // no idling on either side while set
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  always #4 clk = ~clk;

  project_segment_to_z_plane_core u_top (.*);

  // Check transfers at the rising edge; count cycles without progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_segment(in_tdata);
      if (out_tvalid && out_tready) sb.check_point(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
  end

  // Send one segment and wait for its transfer; in_tvalid stays high on
  // return so that the next segment can follow without a gap.
  task automatic send_segment(logic signed [15:0] sx, sy, sz, ex, ey, ez, pz);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pz, ez, ey, ex, sz, sy, sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly deep segments with a small reach to the plane, some with depths near the 64 limit, some fully random.
  task automatic send_random();
    logic signed [15:0] sx, sy, sz, ez;
    int kind;
    kind = $urandom_range(9);
    sx = 16'($urandom);
    sy = 16'($urandom);
    if (kind < 6) begin
      sz = 16'($urandom_range(40000) - 32768);
      ez = 16'(sz + $urandom_range(4000, 64));
      send_segment(sx, sy, sz, 16'(sx + $signed($urandom_range(2000)) - 1000),
                   16'(sy + $signed($urandom_range(2000)) - 1000), ez,
                   16'(ez + $signed($urandom_range(8000)) - 4000));
    end else if (kind < 8) begin
      sz = 16'($urandom);
      send_segment(sx, sy, sz, 16'($urandom), 16'($urandom),
                   16'(sz + $urandom_range(70) + 30), 16'($urandom));
    end else begin
      send_segment(sx, sy, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: shallow, boundary depth, extremes, overflow, clamping and window edges.
    send_segment(0, 0, 0, 0, 0, 63, 100);
    send_segment(0, 0, 0, 0, 0, 64, 100);
    send_segment(0, 0, 100, 0, 0, 0, 0);
    send_segment(10, 20, 0, 30, 40, 64, 128);
    send_segment(-32768, 32767, -32768, 32767, -32768, 32767, -32768);
    send_segment(32767, -32768, -32768, -32768, 32767, 32767, 32767);
    send_segment(-32768, -32768, -32768, 32767, 32767, -32704, 32767);
    send_segment(0, 0, 0, 100, -100, 64, 32767);
    send_segment(0, 0, 0, 4096, -4096, 1000, 1000);
    send_segment(0, 0, 0, 4097, 0, 1000, 1000);
    send_segment(0, 0, 0, 0, -4097, 1000, 1000);
    send_segment(100, 100, 0, 200, 0, 100, 200);
    send_segment(-1, -1, -1, -1, -1, -1, -1);
    send_segment(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_segment(16'hAAAA, 16'h5555, 16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'hAAAA);
    in_tvalid <= 1'b0;

    // Hold off until every expected point has come back.
    while (sb.pending_points.size() != 0) @(negedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 600 && i < 800);
      send_random();
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    while (sb.pending_points.size() != 0 && !timed_out) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Checked %0d projected points, %0d of them rejected.", sb.n_checked,
             sb.n_rejected);
    if (sb.errors == 0 && sb.pending_points.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end
endmodule
